FILE: design/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// Lattice patch bond counter package
// Shared widths, codes, sequencer states and store control for the block.
// ----------------------------------------------------------------------------
package lpbc_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_SPECIES  = 4;

    localparam int OP_W     = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int SITE_W   = 5;
    localparam int LAT_W    = 7;
    localparam int STR_W    = 16;
    localparam int CNT_W    = 3;
    localparam int ENERGY_W = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_WRITE_SITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_TABLE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd2;

    localparam logic [LAT_W-1:0] RST_ROWS     = 7'd64;
    localparam logic [LAT_W-1:0] RST_COLS     = 7'd64;
    localparam logic [STR_W-1:0] RST_STRENGTH = 16'd256;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROWMOD,
        ST_COLMOD,
        ST_SWRITE,
        ST_TWRITE,
        ST_READ,
        ST_BOND,
        ST_DONE
    } lpbc_state_t;

    typedef struct packed {
        logic site_we;
        logic table_we;
    } store_ctrl_t;

endpackage

FILE: design/lpbc_if.sv
// ----------------------------------------------------------------------------
// Lattice patch bond counter channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lpbc_in_if;
    import lpbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SITE_W-1:0] site_value;
    logic [SITE_W-1:0] table_row;
    logic [SITE_W-1:0] table_col;
    logic              table_bit;

    modport source (output valid, operation, row, col, site_value, table_row, table_col,
                    table_bit, input ready);
    modport sink (input valid, operation, row, col, site_value, table_row, table_col,
                  table_bit, output ready);
endinterface

interface lpbc_out_if;
    import lpbc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CNT_W-1:0]           bond_count;
    logic [CNT_W-1:0]           neighbor_count;
    logic                       occupied;
    logic signed [ENERGY_W-1:0] local_energy;

    modport source (output valid, bond_count, neighbor_count, occupied, local_energy,
                    input ready);
    modport sink (input valid, bond_count, neighbor_count, occupied, local_energy,
                  output ready);
endinterface

interface lpbc_cfg_if;
    import lpbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/lpbc_store.sv
// ----------------------------------------------------------------------------
// Lattice patch bond counter store
// Site memory and bond table, each with one port and registered read data,
// swept to zero after reset.
// ----------------------------------------------------------------------------
module lpbc_store #(
    parameter int SITES = 4096,
    parameter int TSIZE = 289
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpbc_pkg::store_ctrl_t          ctrl,
    input  logic [$clog2(SITES)-1:0]       site_addr,
    input  logic [lpbc_pkg::SITE_W-1:0]    site_wdata,
    output logic [lpbc_pkg::SITE_W-1:0]    site_rdata,
    input  logic [$clog2(TSIZE)-1:0]       table_addr,
    input  logic                           table_wdata,
    output logic                           table_rdata,
    output logic                           clearing
);
    import lpbc_pkg::*;

    localparam int AW  = $clog2(SITES);
    localparam int TAW = $clog2(TSIZE);
    localparam int CLR = (SITES > TSIZE) ? SITES : TSIZE;
    localparam int CW  = $clog2(CLR);

    logic [SITE_W-1:0] site_mem [SITES];
    logic              table_mem [TSIZE];

    logic          clearing_reg, clearing_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;

    logic              site_we_eff, table_we_eff;
    logic [AW-1:0]     site_addr_eff;
    logic [TAW-1:0]    table_addr_eff;
    logic [SITE_W-1:0] site_wdata_eff;
    logic              table_wdata_eff;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == CW'(CLR - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            site_we_eff     = ({{(32-CW){1'b0}}, clr_cnt_reg} < 32'(SITES));
            table_we_eff    = ({{(32-CW){1'b0}}, clr_cnt_reg} < 32'(TSIZE));
            site_addr_eff   = AW'(clr_cnt_reg);
            table_addr_eff  = TAW'(clr_cnt_reg);
            site_wdata_eff  = '0;
            table_wdata_eff = 1'b0;
        end
        else
        begin
            site_we_eff     = ctrl.site_we;
            table_we_eff    = ctrl.table_we;
            site_addr_eff   = site_addr;
            table_addr_eff  = table_addr;
            site_wdata_eff  = site_wdata;
            table_wdata_eff = table_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (site_we_eff)
        begin
            site_mem[site_addr_eff] <= site_wdata_eff;
        end
        site_rdata <= site_mem[site_addr_eff];
    end

    always_ff @(posedge clk)
    begin
        if (table_we_eff)
        begin
            table_mem[table_addr_eff] <= table_wdata_eff;
        end
        table_rdata <= table_mem[table_addr_eff];
    end

    assign clearing = clearing_reg;

endmodule

FILE: design/lattice_patch_bond_counter.sv
// ----------------------------------------------------------------------------
// Lattice patch bond counter
// Periodic lattice of site states with a bond table; a query counts the bonds
// and occupied neighbours of one site and gives its local energy in signed Q11.8.
// ----------------------------------------------------------------------------
// A query runs one compare-subtract unit that reduces row and column over six
// steps each, then reads the site and its four neighbours and looks up the bond
// table for each neighbour pair. A site write also reduces row and column first,
// a table write goes straight to its write, and other items straight to the
// result; each item waits there until the output register is free, and only then is
// the next item accepted. After reset a sweep clears both memories first.
// ----------------------------------------------------------------------------
module lattice_patch_bond_counter #(
    parameter int MAX_ROWS = lpbc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lpbc_pkg::DEF_MAX_COLS,
    parameter int SPECIES  = lpbc_pkg::DEF_SPECIES
) (
    input  logic       clk,
    input  logic       rst_n,
    lpbc_in_if.sink    in_item,
    lpbc_out_if.source out_item,
    lpbc_cfg_if.sink   cfg
);
    import lpbc_pkg::*;

    localparam int SITES     = MAX_ROWS * MAX_COLS;
    localparam int STATE_MAX = 4 * SPECIES;
    localparam int TDIM      = STATE_MAX + 1;
    localparam int TSIZE     = TDIM * TDIM;
    localparam int AW        = $clog2(SITES);
    localparam int TAW       = $clog2(TSIZE);

    lpbc_state_t state_reg, state_next;

    logic [LAT_W-1:0] rows_reg, cols_reg;
    logic [STR_W-1:0] strength_reg;

    logic [OP_W-1:0]   op_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic [SITE_W-1:0] sv_reg, tr_reg, tc_reg;
    logic              tb_reg;

    logic [ROW_W-1:0] div_sh_reg;
    logic [LAT_W-1:0] rem_reg, r_reg, c_reg;
    logic [2:0]       step_reg;

    logic [SITE_W-1:0] center_reg;
    logic [SITE_W-1:0] nb_reg [4];
    logic              ok_d_reg;
    logic [CNT_W-1:0]    bc_reg;
    logic [ENERGY_W-1:0] energy_reg;

    logic                out_valid_reg;
    logic [CNT_W-1:0]    out_bc_reg, out_nc_reg;
    logic                out_occ_reg;
    logic [ENERGY_W-1:0] out_energy_reg;

    logic [LAT_W-1:0] eff_rows, eff_cols, divisor;
    logic [LAT_W:0]   trial;
    logic [LAT_W-1:0] rem_new;
    logic [LAT_W-1:0] rd, ru, cl, cr;
    logic             in_acc, step_last, load_out;
    logic             sv_ok, tbl_ok, pair_ok;
    logic [1:0]       k_idx;
    logic [SITE_W-1:0] nbk;
    logic [AW-1:0]    site_addr;
    logic [TAW-1:0]   table_addr;
    logic [SITE_W-1:0] site_rdata;
    logic             table_rdata, clearing;
    logic [CNT_W-1:0] nc_sum;
    store_ctrl_t      ctrl;

    function automatic logic [AW-1:0] site_index(input logic [LAT_W-1:0] r,
                                                 input logic [LAT_W-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    function automatic logic [5:0] rotated(input logic [SITE_W-1:0] v,
                                           input logic [1:0] y);
        logic [SITE_W-1:0] p;
        logic [1:0]        a;
        p = v - SITE_W'(1);
        a = y - p[1:0];
        return 6'({p[4:2], a}) + 6'd1;
    endfunction

    function automatic logic state_ok(input logic [SITE_W-1:0] v);
        return (v != '0) && ({{(32-SITE_W){1'b0}}, v} <= 32'(STATE_MAX));
    endfunction

    // Effective lattice size and the shared restoring compare-subtract step.
    always_comb
    begin
        if (rows_reg == '0)
            eff_rows = LAT_W'(1);
        else if ({{(32-LAT_W){1'b0}}, rows_reg} > 32'(MAX_ROWS))
            eff_rows = LAT_W'(MAX_ROWS);
        else
            eff_rows = rows_reg;
        if (cols_reg == '0)
            eff_cols = LAT_W'(1);
        else if ({{(32-LAT_W){1'b0}}, cols_reg} > 32'(MAX_COLS))
            eff_cols = LAT_W'(MAX_COLS);
        else
            eff_cols = cols_reg;
    end

    assign divisor = (state_reg == ST_COLMOD) ? eff_cols : eff_rows;
    assign trial   = {rem_reg, div_sh_reg[ROW_W-1]};
    assign rem_new = (trial >= {1'b0, divisor}) ? LAT_W'(trial - {1'b0, divisor})
                                                : trial[LAT_W-1:0];

    assign rd = (r_reg + LAT_W'(1) == eff_rows) ? '0 : r_reg + LAT_W'(1);
    assign ru = (r_reg == '0) ? eff_rows - LAT_W'(1) : r_reg - LAT_W'(1);
    assign cr = (c_reg + LAT_W'(1) == eff_cols) ? '0 : c_reg + LAT_W'(1);
    assign cl = (c_reg == '0) ? eff_cols - LAT_W'(1) : c_reg - LAT_W'(1);

    assign in_acc = in_item.valid && in_item.ready;
    assign sv_ok  = ({{(32-SITE_W){1'b0}}, sv_reg} <= 32'(STATE_MAX));
    assign tbl_ok = ({{(32-SITE_W){1'b0}}, tr_reg} < 32'(TDIM))
                 && ({{(32-SITE_W){1'b0}}, tc_reg} < 32'(TDIM));

    assign k_idx   = step_reg[1:0];
    assign nbk     = nb_reg[k_idx];
    assign pair_ok = state_ok(center_reg) && state_ok(nbk) && (step_reg < 3'd4);

    always_comb
    begin
        case (state_reg)
            ST_ROWMOD, ST_COLMOD: step_last = (step_reg == 3'(ROW_W - 1));
            ST_READ:              step_last = (step_reg == 3'd5);
            ST_BOND:              step_last = (step_reg == 3'd4);
            default:              step_last = 1'b0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SWRITE: site_addr = site_index(r_reg, c_reg);
            ST_READ:
            begin
                case (step_reg)
                    3'd1:    site_addr = site_index(rd, c_reg);
                    3'd2:    site_addr = site_index(r_reg, cl);
                    3'd3:    site_addr = site_index(ru, c_reg);
                    3'd4:    site_addr = site_index(r_reg, cr);
                    default: site_addr = site_index(r_reg, c_reg);
                endcase
            end
            default: site_addr = site_index(r_reg, c_reg);
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_TWRITE)
            table_addr = TAW'(tr_reg) * TAW'(TDIM) + TAW'(tc_reg);
        else
            table_addr = TAW'(rotated(center_reg, k_idx + 2'd2)) * TAW'(TDIM)
                       + TAW'(rotated(nbk, k_idx));
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (!clearing) state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc)
                begin
                    if (in_item.operation == OP_WRITE_SITE || in_item.operation == OP_QUERY)
                        state_next = ST_ROWMOD;
                    else if (in_item.operation == OP_WRITE_TABLE)
                        state_next = ST_TWRITE;
                    else
                        state_next = ST_DONE;
                end
            ST_ROWMOD:
                if (step_last) state_next = ST_COLMOD;
            ST_COLMOD:
                if (step_last) state_next = (op_reg == OP_QUERY) ? ST_READ : ST_SWRITE;
            ST_SWRITE, ST_TWRITE:
                state_next = ST_DONE;
            ST_READ:
                if (step_last) state_next = ST_BOND;
            ST_BOND:
                if (step_last) state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || out_item.ready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        in_item.ready = 1'b0;
        ctrl.site_we  = 1'b0;
        ctrl.table_we = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:   in_item.ready = 1'b1;
            ST_SWRITE: ctrl.site_we  = sv_ok;
            ST_TWRITE: ctrl.table_we = tbl_ok;
            ST_DONE:   load_out      = !out_valid_reg || out_item.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            rows_reg      <= RST_ROWS;
            cols_reg      <= RST_COLS;
            strength_reg  <= RST_STRENGTH;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + 3'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_item.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ROWS:     rows_reg     <= cfg.data[LAT_W-1:0];
                    REG_COLS:     cols_reg     <= cfg.data[LAT_W-1:0];
                    REG_STRENGTH: strength_reg <= cfg.data[STR_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign nc_sum = CNT_W'(nb_reg[0] != '0) + CNT_W'(nb_reg[1] != '0)
                  + CNT_W'(nb_reg[2] != '0) + CNT_W'(nb_reg[3] != '0);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= in_item.operation;
            div_sh_reg <= in_item.row;
            col_in_reg <= in_item.col;
            sv_reg     <= in_item.site_value;
            tr_reg     <= in_item.table_row;
            tc_reg     <= in_item.table_col;
            tb_reg     <= in_item.table_bit;
            rem_reg    <= '0;
            bc_reg     <= '0;
            energy_reg <= '0;
        end
        if (state_reg == ST_ROWMOD || state_reg == ST_COLMOD)
        begin
            if (step_last)
            begin
                rem_reg <= '0;
                if (state_reg == ST_ROWMOD)
                begin
                    r_reg      <= rem_new;
                    div_sh_reg <= col_in_reg;
                end
                else
                begin
                    c_reg <= rem_new;
                end
            end
            else
            begin
                rem_reg    <= rem_new;
                div_sh_reg <= {div_sh_reg[ROW_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_READ)
        begin
            case (step_reg)
                3'd1:    center_reg <= site_rdata;
                3'd2:    nb_reg[0]  <= site_rdata;
                3'd3:    nb_reg[1]  <= site_rdata;
                3'd4:    nb_reg[2]  <= site_rdata;
                3'd5:    nb_reg[3]  <= site_rdata;
                default: ;
            endcase
        end
        if (state_reg == ST_BOND)
        begin
            ok_d_reg <= pair_ok;
            if (step_reg != 3'd0 && ok_d_reg && table_rdata)
            begin
                bc_reg     <= bc_reg + CNT_W'(1);
                energy_reg <= energy_reg - ENERGY_W'(strength_reg);
            end
        end
        if (load_out)
        begin
            if (op_reg == OP_QUERY)
            begin
                out_bc_reg     <= bc_reg;
                out_nc_reg     <= nc_sum;
                out_occ_reg    <= (center_reg != '0);
                out_energy_reg <= energy_reg;
            end
            else
            begin
                out_bc_reg     <= '0;
                out_nc_reg     <= '0;
                out_occ_reg    <= 1'b0;
                out_energy_reg <= '0;
            end
        end
    end

    lpbc_store #(
        .SITES (SITES),
        .TSIZE (TSIZE)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .site_addr   (site_addr),
        .site_wdata  (sv_reg),
        .site_rdata  (site_rdata),
        .table_addr  (table_addr),
        .table_wdata (tb_reg),
        .table_rdata (table_rdata),
        .clearing    (clearing)
    );

    assign cfg.ready               = 1'b1;
    assign out_item.valid          = out_valid_reg;
    assign out_item.bond_count     = out_bc_reg;
    assign out_item.neighbor_count = out_nc_reg;
    assign out_item.occupied       = out_occ_reg;
    assign out_item.local_energy   = $signed(out_energy_reg);

    // An empty site never reports bonds.
    a_empty_no_bonds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && !out_item.occupied) |-> (out_item.bond_count == '0))
        else $error("bonds reported for an empty site");

    // Every bond needs an occupied neighbour.
    a_bonds_le_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> (out_item.bond_count <= out_item.neighbor_count))
        else $error("more bonds than occupied neighbours");

    // Without bonds there is no energy.
    a_energy_needs_bonds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.bond_count == '0) |-> (out_item.local_energy == '0))
        else $error("energy without bonds");

    // Once an item is taken the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_item.ready)
        else $error("ready straight after an accepted item");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Lattice patch bond counter testbench
// Drives site writes, bond table writes and site queries through the item
// channels. A model of the site store, the bond table and the lattice
// registers predicts every result, and each result is checked field by field.
// The run covers tiny, clamped and full lattice sizes, strength extremes,
// random idling on both sides, and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import lpbc_pkg::*;

    localparam int STATE_MAX   = 4 * DEF_SPECIES;
    localparam int TABLE_DIM   = STATE_MAX + 1;
    localparam int SITE_COUNT  = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int unsigned FACE_TOP    = 0;
    localparam int unsigned FACE_RIGHT  = 1;
    localparam int unsigned FACE_BOTTOM = 2;
    localparam int unsigned FACE_LEFT   = 3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SITE_W-1:0] site_value;
        logic [SITE_W-1:0] table_row;
        logic [SITE_W-1:0] table_col;
        logic              table_bit;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]    bond_count;
        logic [CNT_W-1:0]    neighbor_count;
        logic                occupied;
        logic [ENERGY_W-1:0] local_energy;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    lpbc_in_if  in_bus ();
    lpbc_out_if out_bus ();
    lpbc_cfg_if cfg_bus ();

    lattice_patch_bond_counter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_bus),
        .out_item (out_bus),
        .cfg      (cfg_bus)
    );

    logic [SITE_W-1:0] site_model [SITE_COUNT];
    logic              bond_model [TABLE_DIM * TABLE_DIM];
    logic [LAT_W-1:0]  rows_reg;
    logic [LAT_W-1:0]  cols_reg;
    logic [STR_W-1:0]  strength_reg;

    result_t     pending_tallies [$];
    int unsigned fail_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned sink_hold_request = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned face_index(int unsigned v, int unsigned face);
        int unsigned p;
        p = v - 1;
        return (p >> 2) * 4 + ((face - (p & 3)) & 3) + 1;
    endfunction

    function automatic int unsigned pair_bonds(int unsigned v1, int unsigned f1,
                                               int unsigned v2, int unsigned f2);
        if (v1 == 0 || v2 == 0 || v1 > STATE_MAX || v2 > STATE_MAX)
            return 0;
        return bond_model[face_index(v1, f1) * TABLE_DIM + face_index(v2, f2)] ? 1 : 0;
    endfunction

    function automatic int unsigned span_of(logic [LAT_W-1:0] value, int unsigned limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    function automatic result_t bond_tally(item_t it);
        result_t     res;
        int unsigned nr, nc, r, c;
        int unsigned centre, below, above, left, right;
        int unsigned bonds, nbrs;
        logic [31:0] product;
        res = '0;
        nr = span_of(rows_reg, DEF_MAX_ROWS);
        nc = span_of(cols_reg, DEF_MAX_COLS);
        r = it.row % nr;
        c = it.col % nc;
        case (it.operation)
            OP_WRITE_SITE:
            begin
                if (it.site_value <= STATE_MAX)
                    site_model[r * DEF_MAX_COLS + c] = it.site_value;
            end
            OP_WRITE_TABLE:
            begin
                if (it.table_row < TABLE_DIM && it.table_col < TABLE_DIM)
                    bond_model[it.table_row * TABLE_DIM + it.table_col] = it.table_bit;
            end
            OP_QUERY:
            begin
                centre = site_model[r * DEF_MAX_COLS + c];
                below  = site_model[((r + 1) % nr) * DEF_MAX_COLS + c];
                above  = site_model[((r + nr - 1) % nr) * DEF_MAX_COLS + c];
                left   = site_model[r * DEF_MAX_COLS + (c + nc - 1) % nc];
                right  = site_model[r * DEF_MAX_COLS + (c + 1) % nc];
                nbrs = 0;
                nbrs += (below != 0) ? 1 : 0;
                nbrs += (left != 0) ? 1 : 0;
                nbrs += (above != 0) ? 1 : 0;
                nbrs += (right != 0) ? 1 : 0;
                bonds = 0;
                if (centre != 0)
                    bonds = pair_bonds(centre, FACE_BOTTOM, below, FACE_TOP)
                          + pair_bonds(centre, FACE_LEFT, left, FACE_RIGHT)
                          + pair_bonds(centre, FACE_TOP, above, FACE_BOTTOM)
                          + pair_bonds(centre, FACE_RIGHT, right, FACE_LEFT);
                product = strength_reg * bonds;
                res.bond_count     = bonds[CNT_W-1:0];
                res.neighbor_count = nbrs[CNT_W-1:0];
                res.occupied       = (centre != 0);
                res.local_energy   = ENERGY_W'(32'd0 - product);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic item_t make_item(logic [OP_W-1:0] op, int unsigned row,
                                        int unsigned col, int unsigned value,
                                        int unsigned trow, int unsigned tcol,
                                        logic tbit);
        item_t it;
        it.operation  = op;
        it.row        = ROW_W'(row);
        it.col        = COL_W'(col);
        it.site_value = SITE_W'(value);
        it.table_row  = SITE_W'(trow);
        it.table_col  = SITE_W'(tcol);
        it.table_bit  = tbit;
        return it;
    endfunction

    function automatic item_t random_item(int unsigned span);
        item_t       it;
        int unsigned pick;
        it.row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom)
                                             : ROW_W'($urandom_range(0, span - 1));
        it.col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom)
                                             : COL_W'($urandom_range(0, span - 1));
        it.site_value = ($urandom_range(0, 4) == 0) ? '0
                                                    : SITE_W'($urandom_range(1, STATE_MAX));
        it.table_row = SITE_W'($urandom_range(1, STATE_MAX));
        it.table_col = SITE_W'($urandom_range(1, STATE_MAX));
        it.table_bit = ($urandom_range(0, 6) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.operation = OP_WRITE_SITE;
        else if (pick < 55)
            it.operation = OP_WRITE_TABLE;
        else if (pick < 95)
            it.operation = OP_QUERY;
        else
        begin
            it.operation  = OP_W'($urandom);
            it.site_value = SITE_W'($urandom);
            it.table_row  = SITE_W'($urandom);
            it.table_col  = SITE_W'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        int unsigned gap;
        result_t     expected;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= it.operation;
        in_bus.row        <= it.row;
        in_bus.col        <= it.col;
        in_bus.site_value <= it.site_value;
        in_bus.table_row  <= it.table_row;
        in_bus.table_col  <= it.table_col;
        in_bus.table_bit  <= it.table_bit;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        expected = bond_tally(it);
        pending_tallies.insert(pending_tallies.size(), expected);
    endtask

    task automatic end_stream();
        in_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_tallies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        case (idx)
            REG_ROWS:     rows_reg = value[LAT_W-1:0];
            REG_COLS:     cols_reg = value[LAT_W-1:0];
            REG_STRENGTH: strength_reg = value[STR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
                                 logic [CFG_DATA_W-1:0] strength);
        end_stream();
        drain_results();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_STRENGTH, strength);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned span, int unsigned count);
        repeat (count) send_item(random_item(span));
    endtask

    task automatic test_directed_cases();
        send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_QUERY, 63, 63, 0, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 0, 0, 1, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 1, 0, 16, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 0, 63, 5, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 63, 0, 9, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 0, 1, 13, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(1, FACE_BOTTOM),
                            face_index(16, FACE_TOP), 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(1, FACE_LEFT),
                            face_index(5, FACE_RIGHT), 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, STATE_MAX, STATE_MAX, 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, 0, 0, 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, 31, 31, 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, STATE_MAX + 1, 2, 1'b1));
        send_item(make_item(OP_WRITE_SITE, 2, 2, STATE_MAX + 1, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 2, 2, 31, 0, 0, 1'b0));
        send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_QUERY, 2, 2, 0, 0, 0, 1'b0));
        send_item(make_item(OP_UNUSED, 63, 63, 31, 31, 31, 1'b1));
        send_item(make_item(OP_QUERY, 1, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_SITE, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 1'b0));
    endtask

    task automatic test_lattice_settings();
        int unsigned v;
        end_stream();
        drain_results();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        apply_setting(16'hFF81, 16'h0001, 16'hFFFF);
        // On a single site every face meets the site itself, so four bonds are possible.
        v = $urandom_range(1, STATE_MAX);
        send_item(make_item(OP_WRITE_SITE, 37, 50, v, 0, 0, 1'b0));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(v, FACE_BOTTOM),
                            face_index(v, FACE_TOP), 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(v, FACE_LEFT),
                            face_index(v, FACE_RIGHT), 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(v, FACE_TOP),
                            face_index(v, FACE_BOTTOM), 1'b1));
        send_item(make_item(OP_WRITE_TABLE, 0, 0, 0, face_index(v, FACE_RIGHT),
                            face_index(v, FACE_LEFT), 1'b1));
        send_item(make_item(OP_QUERY, 63, 63, 0, 0, 0, 1'b0));
        run_phase(1, 30);
        apply_setting(16'd2, 16'd2, 16'd0);
        run_phase(2, 35);
        apply_setting(16'd1, 16'd64, 16'd1);
        run_phase(4, 35);
        apply_setting(16'd64, 16'd1, CFG_DATA_W'($urandom));
        run_phase(4, 35);
        apply_setting(16'd0, 16'd127, 16'h8000);
        run_phase(4, 35);
        apply_setting(16'hFF83, 16'd5, CFG_DATA_W'($urandom));
        run_phase(6, 35);
        apply_setting(16'd64, 16'd64, 16'hFFFF);
        run_phase(6, 40);
    endtask

    task automatic test_output_stall();
        apply_setting(16'd4, 16'd4, 16'd256);
        steady_flow = 1'b1;
        sink_hold_request = 300;
        run_phase(4, 24);
        end_stream();
        drain_results();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        apply_setting(16'd8, 16'd8, 16'd256);
        run_phase(6, 40);
        steady_flow = 1'b1;
        run_phase(6, 30);
        steady_flow = 1'b0;
        apply_setting(16'd64, 16'd64, CFG_DATA_W'($urandom));
        run_phase(5, 70);
        end_stream();
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        result_t     want;
        stall_left = 0;
        hold_left = 0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
            begin
                if (pending_tallies.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = pending_tallies.pop_front();
                    if (out_bus.bond_count !== want.bond_count)
                    begin
                        $error("bond_count: expected %0d, got %0d",
                               want.bond_count, out_bus.bond_count);
                        fail_count++;
                    end
                    if (out_bus.neighbor_count !== want.neighbor_count)
                    begin
                        $error("neighbor_count: expected %0d, got %0d",
                               want.neighbor_count, out_bus.neighbor_count);
                        fail_count++;
                    end
                    if (out_bus.occupied !== want.occupied)
                    begin
                        $error("occupied: expected %0d, got %0d",
                               want.occupied, out_bus.occupied);
                        fail_count++;
                    end
                    if (out_bus.local_energy !== want.local_energy)
                    begin
                        $error("local_energy: expected %0d, got %0d",
                               $signed(want.local_energy), out_bus.local_energy);
                        fail_count++;
                    end
                end
                stall_left = steady_flow ? 0 : $urandom_range(0, 8);
            end
            if (sink_hold_request > 0)
            begin
                hold_left = sink_hold_request;
                sink_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
                (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("lattice_patch_bond_counter test failed");
        $finish;
    end

    initial
    begin : test_sequence
        for (int i = 0; i < SITE_COUNT; i++)
            site_model[i] = '0;
        for (int i = 0; i < TABLE_DIM * TABLE_DIM; i++)
            bond_model[i] = 1'b0;
        rows_reg     = RST_ROWS;
        cols_reg     = RST_COLS;
        strength_reg = RST_STRENGTH;

        rst_n <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= OP_WRITE_SITE;
        in_bus.row        <= '0;
        in_bus.col        <= '0;
        in_bus.site_value <= '0;
        in_bus.table_row  <= '0;
        in_bus.table_col  <= '0;
        in_bus.table_bit  <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_ROWS;
        cfg_bus.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_lattice_settings();
        test_output_stall();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_tallies.size() == 0)
            $display("lattice_patch_bond_counter test passed");
        else
            $display("lattice_patch_bond_counter test failed");
        $finish;
    end

endmodule

FILE: lattice_patch_bond_counter.f
design/lpbc_pkg.sv
design/lpbc_if.sv
design/lpbc_store.sv
design/lattice_patch_bond_counter.sv
sim/tb.sv
